FILE: hw/rtl/farthest_point_centroid_seeding_assert.svh
// ----------------------------------------------------------------------------
// farthest_point_centroid_seeding_assert
// assertion macros for the seeding block, clocked on clk with synchronous reset
// ----------------------------------------------------------------------------
`ifndef FARTHEST_POINT_CENTROID_SEEDING_ASSERT_SVH
`define FARTHEST_POINT_CENTROID_SEEDING_ASSERT_SVH

// property that holds in every cycle out of reset
`define FPCS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked in the next cycle
`define FPCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/fpcs_pkg.sv
// ----------------------------------------------------------------------------
// fpcs_pkg
// shared types and constants of the farthest point seeding block
// ----------------------------------------------------------------------------
package fpcs_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_MAX_DIMS   = 8;
  localparam int DEF_MAX_SEEDS  = 16;

  // fixed field widths
  localparam int COORD_W     = 16;
  localparam int SLOT_W      = 4;
  localparam int INDEX_W     = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int DIMS_REG_W  = 4;
  localparam int NPTS_REG_W  = 11;
  localparam int NCEN_REG_W  = 5;
  localparam int START_REG_W = 10;
  localparam int SQ_W        = 2 * COORD_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTROIDS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_INDEX   = 2'd3;

  // register reset values
  localparam logic [DIMS_REG_W-1:0]  RST_DIMENSIONS    = 4'd2;
  localparam logic [NPTS_REG_W-1:0]  RST_NUM_POINTS    = 11'd1024;
  localparam logic [NCEN_REG_W-1:0]  RST_NUM_CENTROIDS = 5'd4;
  localparam logic [START_REG_W-1:0] RST_START_INDEX   = 10'd0;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SLOT,
    ST_POINT,
    ST_CREAD,
    ST_CIDX,
    ST_READ,
    ST_DATA,
    ST_ACC,
    ST_SQINIT,
    ST_SQRT,
    ST_ADD,
    ST_CMP,
    ST_COMMIT,
    ST_OREAD,
    ST_OVALID
  } state_t;

endpackage

FILE: hw/rtl/farthest_point_centroid_seeding.sv
// ----------------------------------------------------------------------------
// farthest_point_centroid_seeding
// loads a point set and picks k-means seeds by largest summed distance
// ----------------------------------------------------------------------------
// Coordinates stream in one beat per cycle while in_stall is low and are
// written straight into the point memory, points in order and dimensions
// within a point. The beat that completes num_points*dimensions coordinates
// starts selection, and in_stall stays high until every seed has been
// delivered. Slot 0 is start_index (or point 0 when start_index is not below
// the point count); each later slot is the unchosen point with the largest
// saturating sum of q8 distances to the seeds already chosen, lowest index on
// ties. Selection runs one sequencer over the memory: each distance fetches
// the seed from the chosen list, reads, squares and accumulates every
// dimension, takes a bit-serial square root of W/2 steps, where W is the
// radicand width (52 at default size, so 26 steps), and adds the root to the
// sum. Results then leave one seed at a time, each read from the chosen list
// before it is offered. The point memory has no reset and needs no clearing.
module farthest_point_centroid_seeding #(
  parameter int MAX_POINTS = fpcs_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIMS   = fpcs_pkg::DEF_MAX_DIMS,
  parameter int MAX_SEEDS  = fpcs_pkg::DEF_MAX_SEEDS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // coordinate stream
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [fpcs_pkg::COORD_W-1:0] in_coordinate,
  // seed results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fpcs_pkg::SLOT_W-1:0]        out_centroid_slot,
  output logic [fpcs_pkg::INDEX_W-1:0]       out_point_index,
  output logic                               out_last_seed,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fpcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fpcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH   = MAX_POINTS * MAX_DIMS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PI_W    = $clog2(MAX_POINTS);
  localparam int NP_W    = $clog2(MAX_POINTS + 1);
  localparam int DIM_W   = $clog2(MAX_DIMS + 1);
  localparam int SEED_W  = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int SEED_W1 = $clog2(MAX_SEEDS + 1);
  localparam int ACC_W   = fpcs_pkg::SQ_W + $clog2(MAX_DIMS);
  localparam int XR_W    = ACC_W + 16;
  localparam int X_W     = XR_W + (XR_W % 2);
  localparam int DIST_W  = X_W / 2;
  localparam int IT_W    = $clog2(DIST_W);
  localparam int TOT_W   = NP_W + DIM_W;

  // configuration registers
  logic [fpcs_pkg::DIMS_REG_W-1:0]  dims_reg_r;
  logic [fpcs_pkg::NPTS_REG_W-1:0]  npts_reg_r;
  logic [fpcs_pkg::NCEN_REG_W-1:0]  ncen_reg_r;
  logic [fpcs_pkg::START_REG_W-1:0] start_reg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_reg_r  <= fpcs_pkg::RST_DIMENSIONS;
      npts_reg_r  <= fpcs_pkg::RST_NUM_POINTS;
      ncen_reg_r  <= fpcs_pkg::RST_NUM_CENTROIDS;
      start_reg_r <= fpcs_pkg::RST_START_INDEX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpcs_pkg::REG_DIMENSIONS:    dims_reg_r  <= cfg_data[fpcs_pkg::DIMS_REG_W-1:0];
        fpcs_pkg::REG_NUM_POINTS:    npts_reg_r  <= cfg_data[fpcs_pkg::NPTS_REG_W-1:0];
        fpcs_pkg::REG_NUM_CENTROIDS: ncen_reg_r  <= cfg_data[fpcs_pkg::NCEN_REG_W-1:0];
        fpcs_pkg::REG_START_INDEX:   start_reg_r <= cfg_data[fpcs_pkg::START_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped working values, zero counts as one
  logic [DIM_W-1:0]   dims_c;
  logic [NP_W-1:0]    np_c;
  logic [SEED_W1-1:0] k_c;
  logic [SEED_W1-1:0] count_c;
  logic [TOT_W-1:0]   total_c;

  always_comb begin
    if (dims_reg_r == '0)                dims_c = DIM_W'(1);
    else if (32'(dims_reg_r) > MAX_DIMS) dims_c = DIM_W'(MAX_DIMS);
    else                                 dims_c = DIM_W'(dims_reg_r);
    if (npts_reg_r == '0)                  np_c = NP_W'(1);
    else if (32'(npts_reg_r) > MAX_POINTS) np_c = NP_W'(MAX_POINTS);
    else                                   np_c = NP_W'(npts_reg_r);
    if (ncen_reg_r == '0)                 k_c = SEED_W1'(1);
    else if (32'(ncen_reg_r) > MAX_SEEDS) k_c = SEED_W1'(MAX_SEEDS);
    else                                  k_c = SEED_W1'(ncen_reg_r);
    count_c = (32'(k_c) < 32'(np_c)) ? k_c : SEED_W1'(np_c);
    total_c = TOT_W'(np_c) * TOT_W'(dims_c);
  end

  fpcs_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]   load_cnt_r;
  logic [NP_W-1:0]    p_r;
  logic [ADDR_W-1:0]  pbase_r;
  logic [ADDR_W-1:0]  cbase_r;
  logic [SEED_W1-1:0] s_r;
  logic [SEED_W1-1:0] c_r;
  logic [SEED_W1-1:0] o_r;
  logic [DIM_W-1:0]   d_r;
  logic               hit_r;
  logic               found_r;
  logic [31:0]        psum_r;
  logic [31:0]        best_sum_r;
  logic [PI_W-1:0]    best_idx_r;
  logic [fpcs_pkg::SQ_W-1:0] sq_r;
  logic [ACC_W-1:0]   acc_r;
  logic [X_W-1:0]     sx_r;
  logic [X_W-1:0]     sres_r;
  logic [X_W-1:0]     sbit_r;
  logic [IT_W-1:0]    it_r;

  logic in_acc, out_acc, load_done;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign load_done = (TOT_W'(load_cnt_r) + TOT_W'(1)) >= total_c;

  // point memory, one write port and two registered read ports
  logic [fpcs_pkg::COORD_W-1:0] point_mem [DEPTH];
  logic [fpcs_pkg::COORD_W-1:0] qa_r, qb_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      point_mem[load_cnt_r[ADDR_W-1:0]] <= in_coordinate;
    end
    qa_r <= point_mem[pbase_r + ADDR_W'(d_r)];
    qb_r <= point_mem[cbase_r + ADDR_W'(d_r)];
  end

  // chosen list, registered read at the current seed or output slot
  logic [PI_W-1:0]   chosen_mem [MAX_SEEDS];
  logic [PI_W-1:0]   ch_q_r;
  logic [SEED_W1-1:0] ch_raddr;
  logic              ch_we;
  logic [SEED_W1-1:0] ch_waddr;
  logic [PI_W-1:0]   ch_wdata;

  always_comb begin
    ch_raddr = (state_r == fpcs_pkg::ST_OREAD || state_r == fpcs_pkg::ST_OVALID) ? o_r : c_r;
    ch_we    = 1'b0;
    ch_waddr = s_r;
    ch_wdata = best_idx_r;
    if (state_r == fpcs_pkg::ST_LOAD && in_acc && load_done) begin
      ch_we    = 1'b1;
      ch_waddr = '0;
      ch_wdata = (32'(start_reg_r) < 32'(np_c)) ? PI_W'(start_reg_r) : '0;
    end else if (state_r == fpcs_pkg::ST_COMMIT) begin
      ch_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      chosen_mem[ch_waddr[SEED_W-1:0]] <= ch_wdata;
    end
    ch_q_r <= chosen_mem[ch_raddr[SEED_W-1:0]];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpcs_pkg::ST_LOAD: begin
        if (in_acc && load_done) begin
          state_nxt = (count_c == SEED_W1'(1)) ? fpcs_pkg::ST_OREAD : fpcs_pkg::ST_SLOT;
        end
      end
      fpcs_pkg::ST_SLOT:   state_nxt = fpcs_pkg::ST_POINT;
      fpcs_pkg::ST_POINT:  state_nxt = fpcs_pkg::ST_CREAD;
      fpcs_pkg::ST_CREAD:  state_nxt = fpcs_pkg::ST_CIDX;
      fpcs_pkg::ST_CIDX:   state_nxt = fpcs_pkg::ST_READ;
      fpcs_pkg::ST_READ:   state_nxt = fpcs_pkg::ST_DATA;
      fpcs_pkg::ST_DATA:   state_nxt = fpcs_pkg::ST_ACC;
      fpcs_pkg::ST_ACC: begin
        state_nxt = (d_r + DIM_W'(1) == dims_c) ? fpcs_pkg::ST_SQINIT : fpcs_pkg::ST_READ;
      end
      fpcs_pkg::ST_SQINIT: state_nxt = fpcs_pkg::ST_SQRT;
      fpcs_pkg::ST_SQRT: begin
        if (it_r == IT_W'(DIST_W - 1)) state_nxt = fpcs_pkg::ST_ADD;
      end
      fpcs_pkg::ST_ADD: begin
        state_nxt = (c_r + SEED_W1'(1) == s_r) ? fpcs_pkg::ST_CMP : fpcs_pkg::ST_CREAD;
      end
      fpcs_pkg::ST_CMP: begin
        state_nxt = (p_r + NP_W'(1) == np_c) ? fpcs_pkg::ST_COMMIT : fpcs_pkg::ST_POINT;
      end
      fpcs_pkg::ST_COMMIT: begin
        state_nxt = (s_r + SEED_W1'(1) == count_c) ? fpcs_pkg::ST_OREAD : fpcs_pkg::ST_SLOT;
      end
      fpcs_pkg::ST_OREAD:  state_nxt = fpcs_pkg::ST_OVALID;
      fpcs_pkg::ST_OVALID: begin
        if (out_acc) begin
          state_nxt = (o_r + SEED_W1'(1) == count_c) ? fpcs_pkg::ST_LOAD : fpcs_pkg::ST_OREAD;
        end
      end
      default: state_nxt = fpcs_pkg::ST_LOAD;
    endcase
  end

  // port outputs
  always_comb begin
    in_stall          = (state_r != fpcs_pkg::ST_LOAD);
    out_valid         = (state_r == fpcs_pkg::ST_OVALID);
    out_centroid_slot = fpcs_pkg::SLOT_W'(o_r);
    out_point_index   = fpcs_pkg::INDEX_W'(ch_q_r);
    out_last_seed     = (o_r + SEED_W1'(1) == count_c);
  end

  // distance arithmetic
  logic signed [fpcs_pkg::COORD_W:0] diff;
  logic [fpcs_pkg::COORD_W-1:0]      mag;
  logic [X_W-1:0]                    strial;
  logic [32:0]                       psum_ext;
  logic [PI_W+DIM_W-1:0]             cbase_full;

  always_comb begin
    diff       = {qa_r[fpcs_pkg::COORD_W-1], qa_r} - {qb_r[fpcs_pkg::COORD_W-1], qb_r};
    mag        = diff[fpcs_pkg::COORD_W] ? fpcs_pkg::COORD_W'(-diff)
                                         : diff[fpcs_pkg::COORD_W-1:0];
    strial     = sres_r + sbit_r;
    psum_ext   = {1'b0, psum_r} + 33'(sres_r[DIST_W-1:0]);
    cbase_full = (PI_W+DIM_W)'(ch_q_r) * (PI_W+DIM_W)'(dims_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= fpcs_pkg::ST_LOAD;
      load_cnt_r <= '0;
      s_r        <= '0;
      o_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        load_cnt_r <= load_done ? '0 : load_cnt_r + CNT_W'(1);
        if (load_done) begin
          s_r <= SEED_W1'(1);
          o_r <= '0;
        end
      end
      if (state_r == fpcs_pkg::ST_COMMIT) s_r <= s_r + SEED_W1'(1);
      if (state_r == fpcs_pkg::ST_OVALID && out_acc) o_r <= o_r + SEED_W1'(1);
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      fpcs_pkg::ST_SLOT: begin
        found_r    <= 1'b0;
        best_sum_r <= '0;
        best_idx_r <= '0;
        p_r        <= '0;
        pbase_r    <= '0;
      end
      fpcs_pkg::ST_POINT: begin
        psum_r <= '0;
        hit_r  <= 1'b0;
        c_r    <= '0;
      end
      fpcs_pkg::ST_CIDX: begin
        cbase_r <= ADDR_W'(cbase_full);
        if (NP_W'(ch_q_r) == p_r) hit_r <= 1'b1;
        d_r   <= '0;
        acc_r <= '0;
      end
      fpcs_pkg::ST_DATA: sq_r <= mag * mag;
      fpcs_pkg::ST_ACC: begin
        acc_r <= acc_r + ACC_W'(sq_r);
        d_r   <= d_r + DIM_W'(1);
      end
      fpcs_pkg::ST_SQINIT: begin
        sx_r   <= X_W'(acc_r) << 16;
        sres_r <= '0;
        sbit_r <= X_W'(1) << (X_W - 2);
        it_r   <= '0;
      end
      fpcs_pkg::ST_SQRT: begin
        if (sx_r >= strial) begin
          sx_r   <= sx_r - strial;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
        it_r   <= it_r + IT_W'(1);
      end
      fpcs_pkg::ST_ADD: begin
        psum_r <= psum_ext[32] ? 32'hFFFF_FFFF : psum_ext[31:0];
        c_r    <= c_r + SEED_W1'(1);
      end
      fpcs_pkg::ST_CMP: begin
        if (!hit_r && (!found_r || psum_r > best_sum_r)) begin
          found_r    <= 1'b1;
          best_sum_r <= psum_r;
          best_idx_r <= PI_W'(p_r);
        end
        p_r     <= p_r + NP_W'(1);
        pbase_r <= pbase_r + ADDR_W'(dims_c);
      end
      default: ;
    endcase
  end

`include "farthest_point_centroid_seeding_assert.svh"

  // no coordinate is taken while seeds are pending
  `FPCS_ASSERT(a_no_load_in_output, !out_valid || in_stall, "coordinate accepted during output")
  // the final seed closes the run
  `FPCS_ASSERT_NEXT(a_last_ends, out_acc && out_last_seed, !out_valid && !in_stall, "run not closed after last seed")
  // slot numbers stay inside the chosen count
  `FPCS_ASSERT(a_slot_range, !out_valid || (o_r < count_c), "output slot beyond seed count")

endmodule
